// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/blmb_pkg.sv =====
// Types and constants of the boot load map builder
package blmb_pkg;
	localparam int unsigned MaxRunDefault = 32;
	localparam logic [23:0] PcBase = 24'h008000;
	localparam logic [23:0] WsBase = 24'h030000;
	localparam logic [1:0] PlatPc = 2'd0;
	localparam logic [1:0] PlatWsBe = 2'd1;
	localparam logic [1:0] PlatWsLe = 2'd2;
	localparam logic RegPlatform = 1'b0;
	localparam logic RegSpt = 1'b1;
	localparam logic [5:0] SptReset = 6'd18;
	localparam logic [7:0] CodeFlag = 8'h40;

	typedef struct packed {
		logic [15:0] lba_sector;
		logic        final_req;
	} in_item_t;

	typedef struct packed {
		logic [63:0] entry_word;
		logic        is_terminator;
		logic        last;
		logic        overflow;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic close;
		logic close_last;
		logic update;
		logic term;
	} ctrl_cmd_t;

	typedef struct packed {
		logic run_open;
		logic extend;
		logic final_req;
		logic out_free;
	} ctrl_sts_t;

	function automatic logic [23:0] base_of(input logic [1:0] plat);
		return (plat == PlatPc) ? PcBase : WsBase;
	endfunction
endpackage

// ===== sv/blmb_ctrl.sv =====
// Sequencer of the load map builder: divide, test, emit
module blmb_ctrl import blmb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ctrl_sts_t  sts,
	output ctrl_cmd_t  cmd
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DIV    = 7'b0000010,
		S_CHECK  = 7'b0000100,
		S_CLOSE1 = 7'b0001000,
		S_UPD    = 7'b0010000,
		S_CLOSE2 = 7'b0100000,
		S_TERM   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [3:0] cnt_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 4'd15) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = (sts.run_open && !sts.extend) ? S_CLOSE1 : S_UPD;
			end
			S_CLOSE1: begin
				if (sts.out_free) begin
					cmd.close = 1'b1;
					cmd.close_last = !sts.final_req;
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d = sts.final_req ? S_CLOSE2 : S_IDLE;
			end
			S_CLOSE2: begin
				if (sts.out_free) begin
					cmd.close = 1'b1;
					state_d = S_TERM;
				end
			end
			S_TERM: begin
				if (sts.out_free) begin
					cmd.term = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_q == S_DIV) ? cnt_q + 4'd1 : 4'd0;
		end
	end
endmodule

// ===== sv/blmb_dp.sv =====
// Datapath: run state, track dividers, entry formatting and output register
module blmb_dp import blmb_pkg::*; #(
	parameter int unsigned MAX_RUN = MaxRunDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  logic       cfg_valid,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	input  ctrl_cmd_t  cmd,
	output ctrl_sts_t  sts,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);
	logic [15:0] sector_q, run_start_q, prev_q;
	logic        final_q;
	logic [5:0]  run_len_q, spt_q;
	logic [23:0] load_addr_q;
	logic [6:0]  count_q;
	logic [1:0]  plat_q;
	logic [15:0] num_a_q, num_b_q;
	logic [6:0]  rem_a_q, rem_b_q;
	logic [6:0]  ra, rb;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        consecutive, same_track, short_enough, same_page;
	logic [24:0] end_addr;
	logic [6:0]  count_next;
	logic [7:0]  code;
	logic [15:0] pg_pc, pg_ws;
	logic [63:0] close_word, term_word;
	logic [1:0]  plat_w;

	assign ra = {rem_a_q[5:0], num_a_q[15]};
	assign rb = {rem_b_q[5:0], num_b_q[15]};

	assign consecutive  = {1'b0, sector_q} == ({1'b0, prev_q} + 17'd1);
	assign same_track   = (spt_q == 6'd0) || (num_a_q == num_b_q);
	assign short_enough = {26'd0, run_len_q} < MAX_RUN;
	assign end_addr     = {1'b0, load_addr_q} + {10'd0, run_len_q, 9'd0};
	assign same_page    = {1'b0, load_addr_q[23:16]} == end_addr[24:16];

	assign sts.run_open  = run_len_q != 6'd0;
	assign sts.extend    = consecutive && same_track && short_enough && same_page;
	assign sts.final_req = final_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign count_next = (count_q == 7'd127) ? count_q : count_q + 7'd1;
	assign code  = CodeFlag | {2'b00, run_len_q - 6'd1};
	assign pg_pc = load_addr_q[19:4];
	assign pg_ws = {1'b0, load_addr_q[23:9]};
	assign plat_w = (cfg_data[1:0] == 2'd3) ? PlatWsLe : cfg_data[1:0];

	always_comb begin
		unique case (plat_q)
			PlatPc: begin
				close_word = {24'd0, run_start_q, pg_pc, code};
				term_word  = {16'd0, 8'h80, 8'h00, 8'hEA, 24'd0};
			end
			PlatWsBe: begin
				close_word = {run_start_q[7:0], run_start_q[15:8], 24'd0,
					pg_ws[7:0], pg_ws[15:8], code};
				term_word  = {16'd0, 8'h03, 40'd0};
			end
			default: begin
				close_word = {code, pg_ws, 24'd0, run_start_q};
				term_word  = {40'd0, 8'h03, 16'd0};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= '0;
			run_len_q   <= '0;
			prev_q      <= '0;
			load_addr_q <= PcBase;
			count_q     <= '0;
			plat_q      <= PlatPc;
			spt_q       <= SptReset;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == RegPlatform) begin
					plat_q <= plat_w;
					if (run_len_q == 6'd0 && count_q == 7'd0)
						load_addr_q <= base_of(plat_w);
				end else begin
					spt_q <= cfg_data;
				end
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.close) begin
				out_valid_q <= 1'b1;
				load_addr_q <= end_addr[23:0];
				run_len_q   <= '0;
				count_q     <= count_next;
			end
			if (cmd.update) begin
				prev_q <= sector_q;
				if (run_len_q == 6'd0) begin
					run_start_q <= sector_q;
					run_len_q   <= 6'd1;
				end else begin
					run_len_q <= run_len_q + 6'd1;
				end
			end
			if (cmd.term) begin
				out_valid_q <= 1'b1;
				run_start_q <= '0;
				run_len_q   <= '0;
				prev_q      <= '0;
				count_q     <= '0;
				load_addr_q <= base_of(plat_q);
			end
		end
	end

	// restoring division of sector and run start by sectors per track
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sector_q <= in_data.lba_sector;
			final_q  <= in_data.final_req;
			num_a_q  <= in_data.lba_sector;
			num_b_q  <= run_start_q;
			rem_a_q  <= '0;
			rem_b_q  <= '0;
		end else if (cmd.div_step) begin
			if (ra >= {1'b0, spt_q}) begin
				rem_a_q <= ra - {1'b0, spt_q};
				num_a_q <= {num_a_q[14:0], 1'b1};
			end else begin
				rem_a_q <= ra;
				num_a_q <= {num_a_q[14:0], 1'b0};
			end
			if (rb >= {1'b0, spt_q}) begin
				rem_b_q <= rb - {1'b0, spt_q};
				num_b_q <= {num_b_q[14:0], 1'b1};
			end else begin
				rem_b_q <= rb;
				num_b_q <= {num_b_q[14:0], 1'b0};
			end
		end
		if (cmd.close) begin
			out_q.entry_word    <= close_word;
			out_q.is_terminator <= 1'b0;
			out_q.last          <= cmd.close_last;
			out_q.overflow      <= count_next >= 7'd64;
		end else if (cmd.term) begin
			out_q.entry_word    <= term_word;
			out_q.is_terminator <= 1'b1;
			out_q.last          <= 1'b1;
			out_q.overflow      <= count_q >= 7'd64;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== sv/boot_load_map_builder_unit.sv =====
// Top level of the boot load map builder
// Usage:
//   in channel (in_valid/in_ready, in_data): one sector number of the loader
//   file per item, final_req set on the last sector of the file.
//   out channel (out_valid/out_ready, out_data): 8-byte load map entries,
//   the terminator flagged with is_terminator; last marks the final result
//   of an input item. An item yields 0, 1 or (final) 2 to 3 results.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 platform,
//   index 1 sectors per track; write only while the block is idle.
// Operation: an item first passes through the two one-bit-a-cycle track
//   dividers (sector and run start) and the run test; its results are then
//   emitted in turn.
// Results leave through one output register; while the receiver stalls the
//   sequencer holds before the next result, but in idle it still takes an item.
// Reset clears the run state, loads the pc base address, platform 0 and
//   18 sectors per track; no clearing pass is needed.
`include "assert_macros.svh"
module boot_load_map_builder_unit import blmb_pkg::*; #(
	parameter int unsigned MAX_RUN = MaxRunDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data
);
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	blmb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	blmb_dp #(.MAX_RUN(MAX_RUN)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	`ASSERT_IMPLIES(a_term_last, clk, arst_n, out_valid && out_data.is_terminator, out_data.last)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_NEXT(a_no_out_early, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid)
endmodule

// ===== verif/boot_load_map_builder_checker.sv =====
// Checker of the boot load map builder: predicts load map entries and compares them
`timescale 1ns / 100ps
module boot_load_map_builder_checker import blmb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_item_t   in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_item_t  out_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	output int         fail_count,
	output int         pending,
	output int         entries_seen
);
	logic [1:0]  plat;
	logic [5:0]  spt;
	logic [15:0] run_first;
	int          run_len;
	logic [15:0] prev_sector;
	logic [23:0] load_addr;
	int          map_entries;
	out_item_t   entry_q[$];

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic logic [23:0] plat_base();
		return (plat == PlatPc) ? PcBase : WsBase;
	endfunction

	// Build the entry of the open run and move the load address past it
	task automatic close_run(input logic is_last);
		logic [7:0]  code;
		logic [15:0] page;
		logic [63:0] w;
		out_item_t   e;
		code = CodeFlag | 8'((run_len - 1) & 6'h3f);
		if (plat == PlatPc) begin
			page = load_addr[19:4];
			w = {24'h0, run_first, page, code};
		end else if (plat == PlatWsBe) begin
			page = {1'b0, load_addr[23:9]};
			w = {run_first[7:0], run_first[15:8], 24'h0, page[7:0], page[15:8], code};
		end else begin
			page = {1'b0, load_addr[23:9]};
			w = {code, page[15:8], page[7:0], 24'h0, run_first};
		end
		load_addr = 24'(load_addr + 512 * run_len);
		run_len = 0;
		if (map_entries < 127) map_entries++;
		e.entry_word = w;
		e.is_terminator = 1'b0;
		e.last = is_last;
		e.overflow = map_entries >= 64;
		entry_q.insert(entry_q.size(), e);
	endtask

	task automatic predict_entries(input in_item_t it);
		logic       extend;
		int         la_end;
		out_item_t  e;
		if (run_len != 0) begin
			la_end = int'(load_addr) + 512 * run_len;
			extend = (it.lba_sector == 17'(prev_sector) + 17'd1)
				&& (spt == 0 || it.lba_sector / spt == run_first / spt)
				&& run_len < MaxRunDefault
				&& (int'(load_addr) >> 16) == (la_end >> 16);
			if (extend) begin
				run_len++;
			end else begin
				close_run(!it.final_req);
			end
		end
		if (run_len == 0) begin
			run_first = it.lba_sector;
			run_len = 1;
		end
		prev_sector = it.lba_sector;
		if (it.final_req) begin
			close_run(1'b0);
			case (plat)
				PlatPc: e.entry_word = 64'h0000_8000_ea00_0000;
				PlatWsBe: e.entry_word = 64'h0000_0300_0000_0000;
				default: e.entry_word = 64'h0000_0000_0003_0000;
			endcase
			e.is_terminator = 1'b1;
			e.last = 1'b1;
			e.overflow = map_entries >= 64;
			entry_q.insert(entry_q.size(), e);
			run_first = '0;
			run_len = 0;
			prev_sector = '0;
			load_addr = plat_base();
			map_entries = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_e;
		if (!arst_n) begin
			plat = PlatPc;
			spt = SptReset;
			run_first = '0;
			run_len = 0;
			prev_sector = '0;
			load_addr = PcBase;
			map_entries = 0;
			entry_q.delete();
			fail_count = 0;
			entries_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == RegPlatform) begin
					plat = (cfg_data[1:0] == 2'd3) ? PlatWsLe : cfg_data[1:0];
					if (run_len == 0 && map_entries == 0) load_addr = plat_base();
				end else begin
					spt = cfg_data;
				end
			end
			if (out_valid && out_ready) begin
				entries_seen++;
				if (entry_q.size() == 0) begin
					report($sformatf("unexpected entry %h", out_data.entry_word));
				end else begin
					exp_e = entry_q.pop_front();
					if (out_data.entry_word !== exp_e.entry_word)
						report($sformatf("entry_word %h, want %h",
							out_data.entry_word, exp_e.entry_word));
					if (out_data.is_terminator !== exp_e.is_terminator)
						report("is_terminator differs");
					if (out_data.last !== exp_e.last)
						report("last differs");
					if (out_data.overflow !== exp_e.overflow)
						report("overflow differs");
				end
			end
			if (in_valid && in_ready) predict_entries(in_data);
		end
		pending = entry_q.size();
	end
endmodule

// ===== verif/boot_load_map_builder_unit_test.sv =====
// Testbench top of the boot load map builder: stimulus, idling and verdict
`timescale 1ns / 100ps
module boot_load_map_builder_unit_test;
	import blmb_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [5:0] cfg_data;
	int         fail_count;
	int         pending;
	int         entries_seen;
	int         sectors_sent;
	bit         calm;
	bit         hold_go;

	boot_load_map_builder_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	boot_load_map_builder_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .entries_seen(entries_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Timeout");
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_go = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_sector(input logic [15:0] sector, input logic fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_data.lba_sector <= sector;
		in_data.final_req <= fin;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sectors_sent++;
	endtask

	// Drain the block, then let it settle before touching a register
	task automatic write_reg(input logic idx, input logic [5:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_maps(input int n);
		logic [15:0] first;
		int          len;
		int          sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 4) == 0) begin
				send_sector(16'($urandom), $urandom_range(0, 7) == 0);
				sent++;
			end else begin
				first = 16'($urandom);
				len = $urandom_range(1, 40);
				for (int i = 0; i < len; i++)
					send_sector(first + 16'(i), i == len - 1 && $urandom_range(0, 2) == 0);
				sent += len;
			end
		end
		send_sector(16'($urandom), 1'b1);
	endtask

	initial begin
		calm = 0;
		hold_go = 0;
		sectors_sent = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= RegPlatform;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset settings: pc layout, 18 sectors per track
		send_sector(16'd0, 1'b0);
		send_sector(16'd1, 1'b0);
		send_sector(16'd17, 1'b0);
		send_sector(16'd18, 1'b0);
		send_sector(16'd19, 1'b0);
		send_sector(16'hffff, 1'b0);
		send_sector(16'h0000, 1'b0);
		send_sector(16'h5a5a, 1'b1);
		send_sector(16'hffff, 1'b1);
		for (int i = 0; i < 66; i++) send_sector(16'(100 + i), i == 65);

		// Layout change with a run still open
		send_sector(16'h1234, 1'b0);
		write_reg(RegPlatform, {4'd0, PlatWsBe});
		send_sector(16'h1235, 1'b1);
		write_reg(RegSpt, 6'd0);
		send_sector(16'h00ff, 1'b0);
		send_sector(16'h0100, 1'b1);
		write_reg(RegPlatform, 6'd3);
		write_reg(RegSpt, 6'd1);
		send_sector(16'd7, 1'b0);
		send_sector(16'd8, 1'b1);
		write_reg(RegSpt, 6'd63);
		random_maps(15);

		// Map past 64 entries, with the receiver held off meanwhile
		write_reg(RegPlatform, {4'd0, PlatPc});
		hold_go = 1;
		for (int i = 0; i < 70; i++) send_sector(16'($urandom) & 16'hfffe, i == 69);

		write_reg(RegPlatform, {4'd0, PlatWsLe});
		write_reg(RegSpt, 6'($urandom_range(1, 63)));
		random_maps(15);
		write_reg(RegPlatform, {4'd0, PlatWsBe});
		write_reg(RegSpt, 6'd0);
		random_maps(15);
		write_reg(RegPlatform, {4'd0, PlatPc});
		write_reg(RegSpt, SptReset);
		calm = 1;
		random_maps(15);

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d sectors and checked %0d load map entries", sectors_sent,
			entries_seen);
		$display("Covered all layouts, track sizes 0, 1, 18 and 63, long runs and overflow");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
